### sv/assert_macros.svh
// Assertion macros used by the bound checker efsa_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/efsa_pkg.sv
`default_nettype none
package efsa_pkg;

  localparam int DUR_W     = 16;
  localparam int CNT_W     = 5;
  localparam int SRV_W     = 5;
  localparam int OUT_W     = 16;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN1 = 4'b0010,
    S_SCAN2 = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Broadcast command to every cell.
  typedef struct packed {
    logic clr;
    logic wr;
  } cmd_t;

  // Scan token travelling down the chain.
  typedef struct packed {
    logic tok;
    logic have;
  } link_t;

endpackage
`default_nettype wire

### sv/efsa_cell.sv
`default_nettype none
module efsa_cell #(
  parameter int TIME_BITS = 48,
  parameter int IW        = 4,
  parameter int INDEX     = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  active,
  input  efsa_pkg::cmd_t       cmd,
  input  wire [IW-1:0]         wr_idx,
  input  wire [TIME_BITS-1:0]  wr_val,
  input  efsa_pkg::link_t      link_in,
  input  wire [TIME_BITS-1:0]  val_in,
  input  wire [IW-1:0]         idx_in,
  output efsa_pkg::link_t      link_out,
  output logic [TIME_BITS-1:0] val_out,
  output logic [IW-1:0]        idx_out
);
  import efsa_pkg::*;

  logic [TIME_BITS-1:0] free_time;
  logic                 take;

  // Strict compare keeps the lower index on equal times.
  assign take = active && (!link_in.have || (free_time < val_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      free_time <= '0;
    end else if (cmd.clr) begin
      free_time <= '0;
    end else if (cmd.wr && (wr_idx == IW'(INDEX))) begin
      free_time <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.tok  <= link_in.tok;
      link_out.have <= link_in.have || active;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      val_out <= free_time;
      idx_out <= IW'(INDEX);
    end else begin
      val_out <= val_in;
      idx_out <= idx_in;
    end
  end

endmodule
`default_nettype wire

### sv/earliest_free_server_assign.sv
// Clear request: the FSM goes from idle to the done state, which stages the result for output.
// Serve request: two chain scans, then the done state stages the result for output.
// One request at a time; the next is accepted once the result is staged for output.
// The result register lets a new request be accepted while a result waits.
// Synchronous active-high reset zeroes all free times and sets server_count to 16.
`default_nettype none
module earliest_free_server_assign #(
  parameter int MAX_SERVERS = 16,
  parameter int TIME_BITS   = 48
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [efsa_pkg::CNT_W-1:0]    cfg_data,    // server_count
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [efsa_pkg::DUR_W-1:0]    s_axis_tdata, // [15:0] service_time
  input  wire                          s_axis_tuser, // [0] func
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [efsa_pkg::OUT_W-1:0]   m_axis_tdata  // [4:0] served_by, [9:5] next_server,
                                                     // [10] saturated, [15:11] zero
);
  import efsa_pkg::*;

  localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  logic [CNT_W-1:0]     server_count;
  state_t               state;
  logic                 start;
  logic [DUR_W-1:0]     dur;
  logic [SRV_W-1:0]     res_served;
  logic [SRV_W-1:0]     res_next;
  logic                 res_sat;

  link_t                link [0:MAX_SERVERS];
  logic [TIME_BITS-1:0] vals [0:MAX_SERVERS];
  logic [IW-1:0]        idxs [0:MAX_SERVERS];
  logic [MAX_SERVERS-1:0] active;

  cmd_t                 cmd;
  logic                 end_tok;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] upd;
  logic [IW:0]          idx_p1;
  logic                 accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign link[0].tok  = start;
  assign link[0].have = 1'b0;
  assign vals[0]      = '0;
  assign idxs[0]      = '0;

  assign end_tok = link[MAX_SERVERS].tok;
  assign sum     = {1'b0, vals[MAX_SERVERS]} + (TIME_BITS+1)'(dur);
  assign upd     = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign idx_p1  = {1'b0, idxs[MAX_SERVERS]} + (IW+1)'(1);

  assign cmd.clr = accept && !s_axis_tuser;
  assign cmd.wr  = (state == S_SCAN1) && end_tok;

  genvar g;
  generate
    for (g = 0; g < MAX_SERVERS; g++) begin : g_cell
      // A count of zero still leaves the first server active.
      assign active[g] = (g == 0) || (32'(server_count) > g);

      efsa_cell #(
        .TIME_BITS (TIME_BITS),
        .IW        (IW),
        .INDEX     (g)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .active   (active[g]),
        .cmd      (cmd),
        .wr_idx   (idxs[MAX_SERVERS]),
        .wr_val   (upd),
        .link_in  (link[g]),
        .val_in   (vals[g]),
        .idx_in   (idxs[g]),
        .link_out (link[g+1]),
        .val_out  (vals[g+1]),
        .idx_out  (idxs[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      server_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      start         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              start <= 1'b1;
              state <= S_SCAN1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN1: begin
          // The winner is written at this edge; the second scan sees it.
          if (end_tok) begin
            start <= 1'b1;
            state <= S_SCAN2;
          end
        end
        S_SCAN2: begin
          if (end_tok) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dur <= s_axis_tdata;
      if (!s_axis_tuser) begin
        res_served <= '0;
        res_next   <= SRV_W'(1);
        res_sat    <= 1'b0;
      end
    end
    if ((state == S_SCAN1) && end_tok) begin
      res_served <= SRV_W'(idx_p1);
      res_sat    <= &upd;
    end
    if ((state == S_SCAN2) && end_tok) begin
      res_next <= SRV_W'(idx_p1);
    end
    if ((state == S_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {5'b0, res_sat, res_next, res_served};
    end
  end

endmodule
`default_nettype wire

### sv/efsa_checker.sv
`default_nettype none
`include "assert_macros.svh"
module efsa_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        cfg_valid,
  input wire                        cfg_ready,
  input wire [efsa_pkg::CNT_W-1:0]  cfg_data,
  input wire                        s_axis_tvalid,
  input wire                        s_axis_tready,
  input wire [efsa_pkg::DUR_W-1:0]  s_axis_tdata,
  input wire                        s_axis_tuser,
  input wire                        m_axis_tvalid,
  input wire                        m_axis_tready,
  input wire [efsa_pkg::OUT_W-1:0]  m_axis_tdata
);
  import efsa_pkg::*;

  // A waiting result is held until taken.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // Padding above the result fields stays zero.
  `ASSERT_SAME(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[15:11] == 5'd0)
  // A clear result never reports saturation.
  `ASSERT_SAME(a_clear_sat, clk, rst, m_axis_tvalid && (m_axis_tdata[4:0] == 5'd0),
               !m_axis_tdata[10])
  // The next server is always a real server number.
  `ASSERT_SAME(a_next_nz, clk, rst, m_axis_tvalid, m_axis_tdata[9:5] != 5'd0)

endmodule

bind earliest_free_server_assign efsa_checker u_efsa_checker (.*);
`default_nettype wire

### tb/sv/server_assign_checker.sv
`timescale 1ns / 100ps
module server_assign_checker #(
  parameter int MAX_SERVERS = 16,
  parameter int TIME_BITS   = 48,
  parameter bit SERVE_CODE  = 1'b1
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_valid,
  input  wire                           cfg_ready,
  input  wire [efsa_pkg::CNT_W-1:0]     cfg_data,
  input  wire                           s_axis_tvalid,
  input  wire                           s_axis_tready,
  input  wire [efsa_pkg::DUR_W-1:0]     s_axis_tdata,  // [15:0] service_time
  input  wire                           s_axis_tuser,  // [0] func
  input  wire                           m_axis_tvalid,
  input  wire                           m_axis_tready,
  input  wire [efsa_pkg::OUT_W-1:0]     m_axis_tdata,  // [4:0] served_by, [9:5] next_server,
                                                       // [10] saturated, [15:11] zero
  output int                            errors,
  output int                            pending
);
  import efsa_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int PAD_LSB = 2 * SRV_W + 1;

  typedef struct packed {
    logic [SRV_W-1:0] served_by;
    logic [SRV_W-1:0] next_server;
    logic             saturated;
  } assignment_t;

  logic [TIME_BITS-1:0] free_at [MAX_SERVERS];
  logic [CNT_W-1:0]     server_count;
  assignment_t          expected_assignments [$];
  int                   fail_count = 0;

  function automatic int unsigned servers_in_use();
    if (server_count == 0) return 1;
    if (server_count > MAX_SERVERS) return MAX_SERVERS;
    return server_count;
  endfunction

  // Lowest index wins on equal free times.
  function automatic int unsigned earliest_free(input int unsigned n);
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < n; i++)
      if (free_at[i] < free_at[best]) best = i;
    return best;
  endfunction

  function automatic assignment_t assign_request(input logic is_serve,
                                                 input logic [DUR_W-1:0] dur);
    assignment_t          res;
    int unsigned          n;
    int unsigned          k;
    logic [TIME_BITS-1:0] dur_ext;
    logic [TIME_BITS-1:0] upd;
    n = servers_in_use();
    res = '0;
    dur_ext = '0;
    dur_ext[DUR_W-1:0] = dur;
    if (is_serve != SERVE_CODE) begin
      foreach (free_at[i]) free_at[i] = '0;
    end else begin
      k = earliest_free(n);
      if (dur_ext > TIME_MAX - free_at[k]) upd = TIME_MAX;
      else upd = free_at[k] + dur_ext;
      free_at[k] = upd;
      res.saturated = (upd == TIME_MAX);
      res.served_by = SRV_W'(k + 1);
    end
    res.next_server = SRV_W'(earliest_free(n) + 1);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    assignment_t want;
    if (rst) begin
      foreach (free_at[i]) free_at[i] = '0;
      server_count = CNT_RESET;
      expected_assignments.delete();
    end else begin
      if (cfg_valid && cfg_ready) server_count = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        expected_assignments.push_back(assign_request(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_assignments.size() == 0) begin
          $error("result %h arrived with no request outstanding", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_assignments.pop_front();
          compare_field("served_by", OUT_W'(want.served_by), OUT_W'(m_axis_tdata[SRV_W-1:0]));
          compare_field("next_server", OUT_W'(want.next_server),
                        OUT_W'(m_axis_tdata[2*SRV_W-1:SRV_W]));
          compare_field("saturated", OUT_W'(want.saturated), OUT_W'(m_axis_tdata[2*SRV_W]));
          compare_field("padding", '0, OUT_W'(m_axis_tdata[OUT_W-1:PAD_LSB]));
        end
      end
    end
    pending <= expected_assignments.size();
    errors <= fail_count;
  end

endmodule

### tb/sv/earliest_free_server_assign_test.sv
`timescale 1ns / 100ps
module earliest_free_server_assign_test;
  import efsa_pkg::*;

  localparam int MAX_SERVERS  = 16;
  localparam int TIME_BITS    = 48;
  localparam bit REQ_CLEAR    = 1'b0;
  localparam bit REQ_SERVE    = 1'b1;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASES       = 10;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 500;
  localparam int SETTLE       = 4;
  localparam int TAIL_CYCLES  = 100;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DUR_W-1:0] s_axis_tdata = '0;   // [15:0] service_time
  logic             s_axis_tuser = 1'b0;  // [0] func
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;         // [4:0] served_by, [9:5] next_server,
                                          // [10] saturated, [15:11] zero
  int               error_count;
  int               pending_requests;
  bit               tx_burst = 1'b0;
  bit               rx_burst = 1'b0;
  int               results_taken = 0;

  earliest_free_server_assign #(
    .MAX_SERVERS(MAX_SERVERS),
    .TIME_BITS  (TIME_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  server_assign_checker #(
    .MAX_SERVERS(MAX_SERVERS),
    .TIME_BITS  (TIME_BITS),
    .SERVE_CODE (REQ_SERVE)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (error_count),
    .pending      (pending_requests)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("earliest_free_server_assign_test: done, errors");
    $finish;
  end

  // Valid stays high across back-to-back requests; it is lowered only for a gap.
  task automatic send_request(input bit fn, input logic [DUR_W-1:0] dur);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= dur;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_requests != 0) @(posedge clk);
  endtask

  task automatic set_server_count(input logic [CNT_W-1:0] count);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Small durations are favored so that free times often tie.
  function automatic logic [DUR_W-1:0] random_duration();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DUR_W'($urandom_range(0, 7));
      4, 5, 6:    return DUR_W'($urandom);
      7:          return '1;
      default:    return DUR_W'($urandom_range(16'hF000, 16'hFFFF));
    endcase
  endfunction

  // Receiver side: random stalls, bursts of steady acceptance, and one long hold-off.
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (results_taken == HOLD_AT) hold = LONG_HOLD;
      else hold = rx_burst ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      if (!m_axis_tready) m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      results_taken++;
      if (results_taken % 120 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic [DUR_W-1:0] opening [7] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                      16'h5555, 16'hAAAA, 16'h7FFF};
    logic [CNT_W-1:0] fixed_counts [6] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd5};
    logic [CNT_W-1:0] count;
    bit               fn;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset count of 16: clear, then extremes of the service time.
    send_request(REQ_CLEAR, '0);
    foreach (opening[i]) send_request(REQ_SERVE, opening[i]);
    send_request(REQ_CLEAR, 16'hFFFF);

    // Free times survive count changes; hidden servers come back with their old times.
    set_server_count(5'd4);
    send_request(REQ_SERVE, 16'd5);
    send_request(REQ_SERVE, 16'd1);
    send_request(REQ_SERVE, 16'd2);
    send_request(REQ_SERVE, 16'd3);
    set_server_count(5'd2);
    send_request(REQ_SERVE, 16'd9);
    send_request(REQ_SERVE, 16'd1);
    set_server_count(5'd8);
    send_request(REQ_SERVE, 16'd0);
    send_request(REQ_SERVE, 16'd4);
    // A count of zero acts as one, and anything above the server total is clamped.
    set_server_count(5'd0);
    send_request(REQ_SERVE, 16'd7);
    set_server_count(5'd31);
    send_request(REQ_SERVE, 16'd4);
    set_server_count(5'd1);
    send_request(REQ_SERVE, 16'd1);

    for (int p = 0; p < PHASES; p++) begin
      count = (p < 6) ? fixed_counts[p] : CNT_W'($urandom_range(0, 31));
      set_server_count(count);
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (p == 4 && i == 90) wait_idle();
        if (i % 50 == 49) tx_burst = ($urandom_range(0, 3) == 0);
        fn = ($urandom_range(0, 31) == 0) ? REQ_CLEAR : REQ_SERVE;
        send_request(fn, random_duration());
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("earliest_free_server_assign_test: done, clean");
    end else begin
      $display("earliest_free_server_assign_test: done, errors");
    end
    $finish;
  end

endmodule
